// ===== design/twv_pkg.sv =====
// ----------------------------------------------------------------------------
// twv_pkg
// shared constants and types of the trapped water volume engine
// ----------------------------------------------------------------------------
package twv_pkg;

   // capacity and data widths
   localparam int MAX_COLUMNS = 1024;
   localparam int HEIGHT_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_COLUMNS);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int TOTAL_BITS  = 26;
   localparam int SUM_BITS    = ((TOTAL_BITS > HEIGHT_BITS) ? TOTAL_BITS : HEIGHT_BITS) + 1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

// ===== design/trapped_water_volume.sv =====
// ----------------------------------------------------------------------------
// trapped_water_volume
// trapped rain water engine: loads a profile of column heights with their
// prefix maxima, then scans backward and emits the total trapped volume
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  request | req_valid req_ready req_column_height   | in
//          | req_last_column                         |
//  result  | rsp_valid rsp_ready rsp_water_total     | out
//          | rsp_overflow                            |
//
// one cycle per column while loading: each request within capacity writes one entry
// after the last column the backward scan reads one entry per cycle from
// the column memory through registered read data
// the result waits in place until taken; no request is taken meanwhile
// columns beyond capacity are dropped and flagged in rsp_overflow
// reset clears the sequencer, counters and flags; the memory is not cleared
// ----------------------------------------------------------------------------
module trapped_water_volume (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [15:0]                        req_column_height,
   input  logic                               req_last_column,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [twv_pkg::TOTAL_BITS-1:0]     rsp_water_total,
   output logic                               rsp_overflow
);

   twv_pkg::state_type               state_ff, state_in;
   logic [twv_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [twv_pkg::COUNT_BITS-1:0]   idx_ff, idx_in;
   logic [twv_pkg::COUNT_BITS-1:0]   idx_dec;
   logic [twv_pkg::HEIGHT_BITS-1:0]  run_ff, run_in;
   logic                             ovf_ff, ovf_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic [twv_pkg::HEIGHT_BITS-1:0]  height;
   logic [twv_pkg::HEIGHT_BITS-1:0]  prefix_new;
   logic                             wr_en;
   logic                             rd_en;
   twv_pkg::scan_ctl_type            ctl;

   logic [twv_pkg::HEIGHT_BITS-1:0]  height_mem [twv_pkg::MAX_COLUMNS];
   logic [twv_pkg::HEIGHT_BITS-1:0]  prefix_mem [twv_pkg::MAX_COLUMNS];
   logic [twv_pkg::HEIGHT_BITS-1:0]  rd_height_ff;
   logic [twv_pkg::HEIGHT_BITS-1:0]  rd_prefix_ff;

   // incoming height and running prefix max
   assign height     = req_column_height[twv_pkg::HEIGHT_BITS-1:0];
   assign prefix_new = (height > run_ff) ? height : run_ff;
   assign idx_dec    = idx_ff - twv_pkg::COUNT_BITS'(1);

   // sequencer: next state and outputs
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      run_in      = run_ff;
      ovf_in      = ovf_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      ctl         = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         twv_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < twv_pkg::COUNT_BITS'(twv_pkg::MAX_COLUMNS)) begin
                  wr_en    = 1'b1;
                  run_in   = prefix_new;
                  count_in = count_ff + twv_pkg::COUNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_column) begin
                  state_in  = twv_pkg::ST_SCAN;
                  idx_in    = count_in;
                  ctl.clear = 1'b1;
               end
            end
         end
         twv_pkg::ST_SCAN: begin
            ctl.step = rd_valid_ff;
            if (idx_ff != '0) begin
               rd_en  = 1'b1;
               idx_in = idx_dec;
            end else begin
               state_in = twv_pkg::ST_DONE;
            end
         end
         twv_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = twv_pkg::ST_LOAD;
               count_in = '0;
               run_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = twv_pkg::ST_LOAD;
         end
      endcase
      rd_valid_in = rd_en;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= twv_pkg::ST_LOAD;
         count_ff    <= '0;
         idx_ff      <= '0;
         run_ff      <= '0;
         ovf_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         run_ff      <= run_in;
         ovf_ff      <= ovf_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // column memory: written while loading, read back during the scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         height_mem[count_ff[twv_pkg::ADDR_BITS-1:0]] <= height;
         prefix_mem[count_ff[twv_pkg::ADDR_BITS-1:0]] <= prefix_new;
      end
      if (rd_en) begin
         rd_height_ff <= height_mem[idx_dec[twv_pkg::ADDR_BITS-1:0]];
         rd_prefix_ff <= prefix_mem[idx_dec[twv_pkg::ADDR_BITS-1:0]];
      end
   end

   // backward scan arithmetic
   twv_scan_unit u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_height (rd_height_ff),
      .rd_prefix (rd_prefix_ff),
      .total     (rsp_water_total)
   );

   assign rsp_overflow = ovf_ff;

`ifndef SYNTHESIS
   // never open for a request while a result is pending
   a_ready_vs_result: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while result pending");

   // stored column count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= twv_pkg::COUNT_BITS'(twv_pkg::MAX_COLUMNS))
      else $error("column count beyond capacity");

   // a delivered result starts a fresh profile
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (count_ff == '0 && run_ff == '0 && !ovf_ff))
      else $error("profile state not cleared after result");

   // read data only arrives during the scan
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == twv_pkg::ST_SCAN))
      else $error("memory read outside the scan");
`endif

endmodule

// ===== design/twv_scan_unit.sv =====
// ----------------------------------------------------------------------------
// twv_scan_unit
// shared max / min / subtract / accumulate unit of the backward scan
// ----------------------------------------------------------------------------
module twv_scan_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  twv_pkg::scan_ctl_type                  ctl,
   input  logic [twv_pkg::HEIGHT_BITS-1:0]        rd_height,
   input  logic [twv_pkg::HEIGHT_BITS-1:0]        rd_prefix,
   output logic [twv_pkg::TOTAL_BITS-1:0]         total
);

   logic [twv_pkg::HEIGHT_BITS-1:0] suffix_ff, suffix_in;
   logic [twv_pkg::TOTAL_BITS-1:0]  total_ff, total_in;
   logic [twv_pkg::HEIGHT_BITS-1:0] limit;
   logic [twv_pkg::HEIGHT_BITS-1:0] depth;
   logic [twv_pkg::SUM_BITS-1:0]    sum;

   // one column: new suffix max, water level, depth, saturating add
   always_comb begin
      suffix_in = (rd_height > suffix_ff) ? rd_height : suffix_ff;
      limit     = (rd_prefix < suffix_in) ? rd_prefix : suffix_in;
      depth     = (limit > rd_height) ? (limit - rd_height) : '0;
      sum       = twv_pkg::SUM_BITS'(total_ff) + twv_pkg::SUM_BITS'(depth);
      if (sum[twv_pkg::SUM_BITS-1:twv_pkg::TOTAL_BITS] != '0) begin
         total_in = '1;
      end else begin
         total_in = sum[twv_pkg::TOTAL_BITS-1:0];
      end
   end

   // accumulator and suffix max registers
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         suffix_ff <= '0;
         total_ff  <= '0;
      end else if (ctl.step) begin
         suffix_ff <= suffix_in;
         total_ff  <= total_in;
      end
   end

   assign total = total_ff;

endmodule
